@@ src/sdfa_pkg.sv @@
package sdfa_pkg;

  // field widths of the channels
  localparam int CMD_W   = 2;
  localparam int STATE_W = 3;
  localparam int SYM_W   = 2;
  localparam int CNT_W   = 16;
  localparam int MASK_W  = 8;

  // final state mask after reset: state 6 accepts
  localparam logic [MASK_W-1:0] MASK_RESET = 8'd64;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_PROC  = 2'd2
  } cmd_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_EMIT
  } seq_state_t;

  // input transaction
  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [STATE_W-1:0] table_state;
    logic [SYM_W-1:0]   table_symbol;
    logic [STATE_W-1:0] table_next;
    logic [SYM_W-1:0]   symbol_class;
    logic               segment_end;
  } in_item_t;

  // result transaction
  typedef struct packed {
    logic [STATE_W-1:0] start_state;
    logic [STATE_W-1:0] end_state;
    logic [CNT_W-1:0]   match_count;
    logic               row_last;
  } out_item_t;

  // engine status toward the channel logic
  typedef struct packed {
    logic idle;
    logic row_vld;
  } eng_stat_t;

endpackage

@@ src/sdfa_ifs.sv @@
interface sdfa_in_if import sdfa_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sdfa_out_if import sdfa_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sdfa_cfg_if import sdfa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/sdfa_ram.sv @@
module sdfa_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rd_data_r <= mem_r[addr];
  end

  assign rdata = rd_data_r;

endmodule

@@ src/sdfa_engine.sv @@
module sdfa_engine import sdfa_pkg::*; #(
  parameter int NUM_STATES  = 8,
  parameter int NUM_SYMBOLS = 4,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    item_take,
  input  in_item_t                item,
  input  logic [MASK_W-1:0]       final_mask,
  output logic                    ram_we,
  output logic [$clog2(NUM_STATES)+$clog2(NUM_SYMBOLS)-1:0] ram_addr,
  output logic [$clog2(NUM_STATES)-1:0] ram_wdata,
  input  logic [$clog2(NUM_STATES)-1:0] ram_rdata,
  output eng_stat_t               stat,
  output out_item_t               row,
  input  logic                    row_take
);

  localparam int SW = $clog2(NUM_STATES);
  localparam int YW = $clog2(NUM_SYMBOLS);
  localparam int CW = $clog2(NUM_STATES + 1);

  seq_state_t state_r, state_nxt;

  logic [CW-1:0]          rd_cnt_r, rd_cnt_nxt;
  logic                   wr_vld_r, wr_vld_nxt;
  logic [SW-1:0]          wr_idx_r, wr_idx_nxt;
  logic [YW-1:0]          sym_r, sym_nxt;
  logic                   last_r, last_nxt;
  logic [SW-1:0]          emit_idx_r, emit_idx_nxt;
  logic [SW-1:0]          trk_r [NUM_STATES];
  logic [SW-1:0]          trk_nxt [NUM_STATES];
  logic [COUNT_WIDTH-1:0] cnt_r [NUM_STATES];
  logic [COUNT_WIDTH-1:0] cnt_nxt [NUM_STATES];

  logic ld_ok;
  logic sym_ok;
  logic rd_issue;
  logic sweep_done;
  logic emit_done;

  // accepting states, no bit for states 8 and above
  function automatic logic is_final(input logic [SW-1:0] s, input logic [MASK_W-1:0] m);
    logic [31:0] sx;
    sx = 32'(s);
    return (sx < 32'd8) && m[sx[2:0]];
  endfunction

  // range checks on the incoming transaction
  assign ld_ok = (32'(item.table_state) < NUM_STATES) &&
                 (32'(item.table_symbol) < NUM_SYMBOLS) &&
                 (32'(item.table_next) < NUM_STATES);
  assign sym_ok = 32'(item.symbol_class) < NUM_SYMBOLS;

  assign sweep_done = rd_cnt_r == CW'(NUM_STATES);
  assign emit_done  = row_take && (emit_idx_r == SW'(NUM_STATES - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (item_take && item.cmd == CMD_PROC) begin
          if (sym_ok) begin
            state_nxt = ST_STEP;
          end else if (item.segment_end) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_STEP: begin
        if (sweep_done) begin
          state_nxt = last_r ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (emit_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    stat.idle    = 1'b0;
    stat.row_vld = 1'b0;
    rd_issue     = 1'b0;
    unique case (state_r)
      ST_IDLE: stat.idle = 1'b1;
      ST_STEP: rd_issue = !sweep_done;
      ST_EMIT: stat.row_vld = 1'b1;
      default: stat.idle = 1'b0;
    endcase
  end

  // table port: loads while idle, one lookup per tracked start state while stepping
  assign ram_we    = item_take && (item.cmd == CMD_LOAD) && ld_ok;
  assign ram_wdata = SW'(item.table_next);
  assign ram_addr  = rd_issue ? {trk_r[rd_cnt_r[SW-1:0]], sym_r}
                              : {SW'(item.table_state), YW'(item.table_symbol)};

  // datapath next values
  always_comb begin
    rd_cnt_nxt   = rd_cnt_r;
    wr_vld_nxt   = rd_issue;
    wr_idx_nxt   = rd_cnt_r[SW-1:0];
    sym_nxt      = sym_r;
    last_nxt     = last_r;
    emit_idx_nxt = emit_idx_r;
    for (int k = 0; k < NUM_STATES; k++) begin
      trk_nxt[k] = trk_r[k];
      cnt_nxt[k] = cnt_r[k];
    end

    // accepted command
    if (state_r == ST_IDLE && item_take) begin
      if (item.cmd == CMD_START) begin
        for (int k = 0; k < NUM_STATES; k++) begin
          trk_nxt[k] = SW'(k);
          cnt_nxt[k] = '0;
        end
      end else if (item.cmd == CMD_PROC) begin
        sym_nxt    = YW'(item.symbol_class);
        last_nxt   = item.segment_end;
        rd_cnt_nxt = '0;
      end
    end

    // walk the read pointer
    if (rd_issue) begin
      rd_cnt_nxt = rd_cnt_r + CW'(1);
    end

    // write back the looked-up state in the cycle after the read
    if (wr_vld_r) begin
      trk_nxt[wr_idx_r] = ram_rdata;
      if (is_final(ram_rdata, final_mask) && (cnt_r[wr_idx_r] != '1)) begin
        cnt_nxt[wr_idx_r] = cnt_r[wr_idx_r] + COUNT_WIDTH'(1);
      end
    end

    // row pointer for emission
    if (state_r != ST_EMIT) begin
      emit_idx_nxt = '0;
    end else if (row_take) begin
      emit_idx_nxt = emit_idx_r + SW'(1);
    end
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      rd_cnt_r   <= '0;
      wr_vld_r   <= 1'b0;
      wr_idx_r   <= '0;
      emit_idx_r <= '0;
      for (int k = 0; k < NUM_STATES; k++) begin
        trk_r[k] <= SW'(k);
        cnt_r[k] <= '0;
      end
    end else begin
      state_r    <= state_nxt;
      rd_cnt_r   <= rd_cnt_nxt;
      wr_vld_r   <= wr_vld_nxt;
      wr_idx_r   <= wr_idx_nxt;
      emit_idx_r <= emit_idx_nxt;
      for (int k = 0; k < NUM_STATES; k++) begin
        trk_r[k] <= trk_nxt[k];
        cnt_r[k] <= cnt_nxt[k];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    sym_r  <= sym_nxt;
    last_r <= last_nxt;
  end

  // current result row
  assign row.start_state = STATE_W'(emit_idx_r);
  assign row.end_state   = STATE_W'(trk_r[emit_idx_r]);
  assign row.match_count = CNT_W'(cnt_r[emit_idx_r]);
  assign row.row_last    = emit_idx_r == SW'(NUM_STATES - 1);

endmodule

@@ src/speculative_dfa_segment_matcher_top.sv @@
// channel   dir  handshake      payload
// in_ch     in   valid/ready    cmd, table_state, table_symbol, table_next,
//                               symbol_class, segment_end
// out_ch    out  valid/ready    start_state, end_state, match_count, row_last
// cfg_ch    in   valid/ready    final_state_mask (always ready)
//
// load and start transactions leave the sequencer idle.
// a process transaction with an in-range symbol_class reads the single-port
// transition table once per tracked start state, writing back in the cycle after each read.
// on segment_end, NUM_STATES rows follow, one per cycle while out_ch is ready.
// in_ch is ready only while the sequencer is idle; out_ch stalls hold emission.
// rst_n is synchronous: tracked states go to identity, counts to zero, mask to 64.
module speculative_dfa_segment_matcher_top import sdfa_pkg::*; #(
  parameter int NUM_STATES  = 8,
  parameter int NUM_SYMBOLS = 4,
  parameter int COUNT_WIDTH = 16
) (
  input logic        clk,
  input logic        rst_n,
  sdfa_in_if.sink    in_ch,
  sdfa_out_if.source out_ch,
  sdfa_cfg_if.sink   cfg_ch
);

  localparam int SW    = $clog2(NUM_STATES);
  localparam int YW    = $clog2(NUM_SYMBOLS);
  localparam int DEPTH = NUM_STATES * (1 << YW);

  logic [MASK_W-1:0] mask_r, mask_nxt;
  logic              out_vld_r, out_vld_nxt;
  out_item_t         out_data_r;

  eng_stat_t         stat;
  out_item_t         row;
  logic              item_take;
  logic              row_take;
  logic              ram_we;
  logic [SW+YW-1:0]  ram_addr;
  logic [SW-1:0]     ram_wdata;
  logic [SW-1:0]     ram_rdata;

  // input handshake
  assign in_ch.ready = stat.idle;
  assign item_take   = in_ch.valid && in_ch.ready;

  // configuration register
  assign cfg_ch.ready = 1'b1;
  assign mask_nxt     = cfg_ch.valid ? cfg_ch.data : mask_r;

  // output register parts the engine from the result channel
  assign row_take    = stat.row_vld && (!out_vld_r || out_ch.ready);
  assign out_vld_nxt = row_take ? 1'b1 : (out_ch.ready ? 1'b0 : out_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r    <= MASK_RESET;
      out_vld_r <= 1'b0;
    end else begin
      mask_r    <= mask_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (row_take) begin
      out_data_r <= row;
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_data_r;

  // transition table
  sdfa_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // sequencer and tracked state update
  sdfa_engine #(
    .NUM_STATES  (NUM_STATES),
    .NUM_SYMBOLS (NUM_SYMBOLS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_take  (item_take),
    .item       (in_ch.data),
    .final_mask (mask_r),
    .ram_we     (ram_we),
    .ram_addr   (ram_addr),
    .ram_wdata  (ram_wdata),
    .ram_rdata  (ram_rdata),
    .stat       (stat),
    .row        (row),
    .row_take   (row_take)
  );

endmodule
